// ===== src/pce_pkg.sv =====
package pce_pkg;

    localparam int KEY_W   = 32;
    localparam int LEN_W   = 20;
    localparam int SIZE_W  = 21;
    localparam int FREQ_W  = 32;
    localparam int TIME_W  = 40;
    localparam int TOK_W   = 32;
    localparam int BS_W    = 16;
    localparam int DECAY_W = 17;
    localparam int POL_W   = 2;
    localparam int EVC_W   = 7;
    localparam int PROD_W  = FREQ_W + DECAY_W;

    // restoring remainder steps, one per bit of the padded length
    localparam int DIV_STEPS = SIZE_W;

    localparam logic [FREQ_W-1:0] ONE_Q16 = FREQ_W'(65536);

    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_CAPACITY = 2'd0;
    localparam logic [1:0] REG_BLOCK    = 2'd1;
    localparam logic [1:0] REG_POLICY   = 2'd2;
    localparam logic [1:0] REG_DECAY    = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
        logic [FREQ_W-1:0] freq;
        logic [TIME_W-1:0] touch;
    } entry_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_KEY_SCAN,
        OP_DIV,
        OP_ROUND,
        OP_MUL,
        OP_TOUCH,
        OP_RESIZE,
        OP_NEW,
        OP_WRITE,
        OP_VIC_SCAN,
        OP_EVICT,
        OP_OUT
    } op_t;

    typedef struct packed {
        logic has_prefix;
        logic found;
        logic free_found;
        logic vic_found;
        logic oversize;
        logic over_cap;
        logic out_busy;
    } status_t;

endpackage

// ===== src/pce_ram.sv =====
module pce_ram #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic                clk,
    input  logic                we,
    input  logic [IDX_W-1:0]    waddr,
    input  pce_pkg::entry_t     wdata,
    input  logic [IDX_W-1:0]    raddr,
    output pce_pkg::entry_t     rdata
);

    pce_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/pce_dp.sv =====
module pce_dp #(
    parameter int ENTRIES = 64,
    parameter int IDX_W   = 6,
    parameter int CNT_W   = 7
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pce_pkg::op_t                    op,
    input  logic [CNT_W-1:0]                cnt,
    output pce_pkg::status_t                stat,
    input  logic [pce_pkg::TOK_W-1:0]       capacity_limit,
    input  logic [pce_pkg::BS_W-1:0]        block_size,
    input  logic [pce_pkg::POL_W-1:0]       evict_policy,
    input  logic [pce_pkg::DECAY_W-1:0]     decay_factor,
    input  logic                            has_prefix,
    input  logic [pce_pkg::KEY_W-1:0]       prefix_key,
    input  logic [pce_pkg::LEN_W-1:0]       prompt_len,
    input  logic                            has_prefix_len,
    input  logic [pce_pkg::LEN_W-1:0]       prefix_len,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [pce_pkg::LEN_W-1:0]       hit_len,
    output logic                            stored,
    output logic [pce_pkg::EVC_W-1:0]       evicted_count,
    output logic [pce_pkg::TOK_W-1:0]       occupied_tokens
);

    logic                           valid_reg [ENTRIES];
    logic [pce_pkg::TOK_W-1:0]      total_reg;
    logic [pce_pkg::TIME_W-1:0]     clock_reg;
    logic                           out_valid_reg;
    logic                           pend_reg;
    logic                           pend_vic_reg;
    logic [IDX_W-1:0]               pend_idx_reg;
    logic                           has_prefix_reg;
    logic                           found_reg;
    logic                           free_found_reg;
    logic                           vic_found_reg;
    logic [IDX_W-1:0]               hit_idx_reg;
    logic [IDX_W-1:0]               free_idx_reg;
    logic [IDX_W-1:0]               vic_idx_reg;
    logic [pce_pkg::SIZE_W-1:0]     vic_size_reg;
    logic [pce_pkg::FREQ_W-1:0]     vic_freq_reg;
    logic [pce_pkg::TIME_W-1:0]     vic_time_reg;
    logic [pce_pkg::KEY_W-1:0]      key_reg;
    logic [pce_pkg::LEN_W-1:0]      prompt_reg;
    logic [pce_pkg::SIZE_W-1:0]     n_reg;
    logic [pce_pkg::SIZE_W-1:0]     nsh_reg;
    logic [pce_pkg::BS_W-1:0]       bs_reg;
    logic [pce_pkg::BS_W-1:0]       rem_reg;
    logic [pce_pkg::SIZE_W-1:0]     rounded_reg;
    logic [pce_pkg::PROD_W-1:0]     prod_reg;
    pce_pkg::entry_t                e_reg;
    logic [pce_pkg::LEN_W-1:0]      hit_reg;
    logic                           stored_reg;
    logic [pce_pkg::EVC_W-1:0]      ev_cnt_reg;
    logic [pce_pkg::LEN_W-1:0]      hit_len_reg;
    logic                           stored_out_reg;
    logic [pce_pkg::EVC_W-1:0]      evc_out_reg;
    logic [pce_pkg::TOK_W-1:0]      occ_out_reg;

    logic [pce_pkg::BS_W-1:0]       bs_eff;
    logic [pce_pkg::LEN_W-1:0]      tokens;
    logic [pce_pkg::BS_W:0]         rem_sh;
    logic [pce_pkg::BS_W-1:0]       rem_next;
    logic [pce_pkg::FREQ_W+1:0]     freq_sum;
    logic [pce_pkg::FREQ_W-1:0]     freq_next;
    logic [pce_pkg::TIME_W-1:0]     clock_next;
    logic                           issue;
    logic                           we;
    pce_pkg::entry_t                rdata;
    logic                           better;
    logic                           by_age;

    assign bs_eff  = (block_size == '0) ? pce_pkg::BS_W'(1) : block_size;
    assign tokens  = has_prefix_len ? prefix_len : prompt_len;
    assign rem_sh  = {rem_reg, nsh_reg[pce_pkg::SIZE_W-1]};
    assign rem_next = (rem_sh >= {1'b0, bs_reg})
                    ? pce_pkg::BS_W'(rem_sh - {1'b0, bs_reg})
                    : pce_pkg::BS_W'(rem_sh);
    assign freq_sum = (pce_pkg::FREQ_W+2)'(prod_reg[pce_pkg::PROD_W-1:16])
                    + (pce_pkg::FREQ_W+2)'(pce_pkg::ONE_Q16);
    assign freq_next = (freq_sum > (pce_pkg::FREQ_W+2)'({pce_pkg::FREQ_W{1'b1}}))
                     ? {pce_pkg::FREQ_W{1'b1}} : freq_sum[pce_pkg::FREQ_W-1:0];
    assign clock_next = clock_reg + pce_pkg::TIME_W'(1);
    assign issue  = ((op == pce_pkg::OP_KEY_SCAN) || (op == pce_pkg::OP_VIC_SCAN))
                  && (cnt < CNT_W'(ENTRIES));
    assign we     = (op == pce_pkg::OP_WRITE);
    assign by_age = (evict_policy < pce_pkg::POL_W'(2));

    // age policies take the oldest touch; frequency policies break ties on age
    always_comb
    begin
        if (by_age)
        begin
            better = rdata.touch < vic_time_reg;
        end
        else
        begin
            better = (rdata.freq < vic_freq_reg)
                  || ((rdata.freq == vic_freq_reg) && (rdata.touch < vic_time_reg));
        end
    end

    pce_ram #(
        .DEPTH (ENTRIES),
        .IDX_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (hit_idx_reg),
        .wdata (e_reg),
        .raddr (cnt[IDX_W-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            total_reg      <= '0;
            clock_reg      <= '0;
            out_valid_reg  <= 1'b0;
            pend_reg       <= 1'b0;
            pend_vic_reg   <= 1'b0;
            has_prefix_reg <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            vic_found_reg  <= 1'b0;
            stored_reg     <= 1'b0;
            ev_cnt_reg     <= '0;
        end
        else
        begin
            pend_reg     <= issue;
            pend_vic_reg <= (op == pce_pkg::OP_VIC_SCAN);
            if (op == pce_pkg::OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // compare the entry read in the previous cycle
            if (pend_reg)
            begin
                if (!pend_vic_reg)
                begin
                    if (valid_reg[pend_idx_reg] && (rdata.key == key_reg) && !found_reg)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (!valid_reg[pend_idx_reg] && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                    end
                end
                else if (valid_reg[pend_idx_reg] && (!vic_found_reg || better))
                begin
                    vic_found_reg <= 1'b1;
                end
            end
            case (op)
                pce_pkg::OP_LOAD:
                begin
                    has_prefix_reg <= has_prefix;
                    found_reg      <= 1'b0;
                    free_found_reg <= 1'b0;
                    stored_reg     <= 1'b0;
                    ev_cnt_reg     <= '0;
                end
                pce_pkg::OP_VIC_SCAN:
                begin
                    if (cnt == '0)
                    begin
                        vic_found_reg <= 1'b0;
                    end
                end
                pce_pkg::OP_TOUCH:
                begin
                    clock_reg <= clock_next;
                end
                pce_pkg::OP_RESIZE:
                begin
                    total_reg  <= total_reg - pce_pkg::TOK_W'(e_reg.size)
                                + pce_pkg::TOK_W'(rounded_reg);
                    stored_reg <= 1'b1;
                end
                pce_pkg::OP_NEW:
                begin
                    total_reg  <= total_reg + pce_pkg::TOK_W'(rounded_reg);
                    stored_reg <= 1'b1;
                end
                pce_pkg::OP_WRITE:
                begin
                    valid_reg[hit_idx_reg] <= 1'b1;
                end
                pce_pkg::OP_EVICT:
                begin
                    valid_reg[vic_idx_reg] <= 1'b0;
                    total_reg  <= total_reg - pce_pkg::TOK_W'(vic_size_reg);
                    ev_cnt_reg <= ev_cnt_reg + pce_pkg::EVC_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= cnt[IDX_W-1:0];
        if (pend_reg)
        begin
            if (!pend_vic_reg)
            begin
                if (valid_reg[pend_idx_reg] && (rdata.key == key_reg) && !found_reg)
                begin
                    hit_idx_reg <= pend_idx_reg;
                    e_reg       <= rdata;
                end
                if (!valid_reg[pend_idx_reg] && !free_found_reg)
                begin
                    free_idx_reg <= pend_idx_reg;
                end
            end
            else if (valid_reg[pend_idx_reg] && (!vic_found_reg || better))
            begin
                vic_idx_reg  <= pend_idx_reg;
                vic_size_reg <= rdata.size;
                vic_freq_reg <= rdata.freq;
                vic_time_reg <= rdata.touch;
            end
        end
        case (op)
            pce_pkg::OP_LOAD:
            begin
                key_reg    <= prefix_key;
                prompt_reg <= prompt_len;
                n_reg      <= pce_pkg::SIZE_W'(tokens) + pce_pkg::SIZE_W'(bs_eff)
                            - pce_pkg::SIZE_W'(1);
                nsh_reg    <= pce_pkg::SIZE_W'(tokens) + pce_pkg::SIZE_W'(bs_eff)
                            - pce_pkg::SIZE_W'(1);
                bs_reg     <= bs_eff;
                rem_reg    <= '0;
                hit_reg    <= '0;
            end
            pce_pkg::OP_DIV:
            begin
                rem_reg <= rem_next;
                nsh_reg <= {nsh_reg[pce_pkg::SIZE_W-2:0], 1'b0};
            end
            pce_pkg::OP_ROUND:
            begin
                rounded_reg <= n_reg - pce_pkg::SIZE_W'(rem_reg);
                if (found_reg)
                begin
                    hit_reg <= (pce_pkg::SIZE_W'(prompt_reg) < e_reg.size)
                             ? prompt_reg : pce_pkg::LEN_W'(e_reg.size);
                end
            end
            pce_pkg::OP_MUL:
            begin
                prod_reg <= pce_pkg::PROD_W'(e_reg.freq) * pce_pkg::PROD_W'(decay_factor);
            end
            pce_pkg::OP_TOUCH:
            begin
                e_reg.freq  <= freq_next;
                e_reg.touch <= clock_next;
            end
            pce_pkg::OP_RESIZE:
            begin
                e_reg.size <= rounded_reg;
            end
            pce_pkg::OP_NEW:
            begin
                e_reg.key   <= key_reg;
                e_reg.size  <= rounded_reg;
                e_reg.freq  <= '0;
                hit_idx_reg <= free_found_reg ? free_idx_reg : vic_idx_reg;
            end
            pce_pkg::OP_OUT:
            begin
                hit_len_reg    <= hit_reg;
                stored_out_reg <= stored_reg;
                evc_out_reg    <= ev_cnt_reg;
                occ_out_reg    <= total_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.has_prefix = has_prefix_reg;
    assign stat.found      = found_reg;
    assign stat.free_found = free_found_reg;
    // include the last entry, still being compared when the scan ends
    assign stat.vic_found  = vic_found_reg
                          || (pend_reg && pend_vic_reg && valid_reg[pend_idx_reg]);
    assign stat.oversize   = (capacity_limit != '0)
                          && (pce_pkg::TOK_W'(rounded_reg) > capacity_limit);
    assign stat.over_cap   = (capacity_limit != '0) && (total_reg > capacity_limit);
    assign stat.out_busy   = out_valid_reg && !out_ready;

    assign out_valid       = out_valid_reg;
    assign hit_len         = hit_len_reg;
    assign stored          = stored_out_reg;
    assign evicted_count   = evc_out_reg;
    assign occupied_tokens = occ_out_reg;

endmodule

// ===== src/pce_ctrl.sv =====
module pce_ctrl #(
    parameter int ENTRIES = 64,
    parameter int CNT_W   = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pce_pkg::status_t    stat,
    output pce_pkg::op_t        op,
    output logic [CNT_W-1:0]    cnt
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_BRANCH,
        S_KEY,
        S_DIV,
        S_ROUND,
        S_HMUL,
        S_HTOUCH,
        S_DECIDE,
        S_HWR,
        S_RESIZE,
        S_RMUL,
        S_RTOUCH,
        S_SWR,
        S_NEW,
        S_VSCAN,
        S_EVICT,
        S_ENF,
        S_OUT
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               full_reg;
    logic               full_next;
    logic               scan_done;
    logic               div_done;

    assign scan_done = (cnt_reg == CNT_W'(ENTRIES));
    assign div_done  = (cnt_reg == CNT_W'(pce_pkg::DIV_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        full_next  = full_reg;
        op         = pce_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = pce_pkg::OP_LOAD;
                    state_next = S_BRANCH;
                end
            end
            S_BRANCH:
            begin
                cnt_next   = '0;
                state_next = stat.has_prefix ? S_KEY : S_OUT;
            end
            S_KEY:
            begin
                op       = pce_pkg::OP_KEY_SCAN;
                cnt_next = cnt_reg + CNT_W'(1);
                if (scan_done)
                begin
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                op       = pce_pkg::OP_DIV;
                cnt_next = cnt_reg + CNT_W'(1);
                if (div_done)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                op         = pce_pkg::OP_ROUND;
                state_next = stat.found ? S_HMUL : S_DECIDE;
            end
            S_HMUL:
            begin
                op         = pce_pkg::OP_MUL;
                state_next = S_HTOUCH;
            end
            S_HTOUCH:
            begin
                op         = pce_pkg::OP_TOUCH;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (stat.oversize)
                begin
                    state_next = stat.found ? S_HWR : S_OUT;
                end
                else if (stat.found)
                begin
                    state_next = S_RESIZE;
                end
                else if (stat.free_found)
                begin
                    state_next = S_NEW;
                end
                else
                begin
                    // every slot taken: make room first
                    full_next  = 1'b1;
                    cnt_next   = '0;
                    state_next = S_VSCAN;
                end
            end
            S_HWR:
            begin
                op         = pce_pkg::OP_WRITE;
                state_next = S_OUT;
            end
            S_RESIZE:
            begin
                op         = pce_pkg::OP_RESIZE;
                state_next = S_RMUL;
            end
            S_NEW:
            begin
                op         = pce_pkg::OP_NEW;
                state_next = S_RMUL;
            end
            S_RMUL:
            begin
                op         = pce_pkg::OP_MUL;
                state_next = S_RTOUCH;
            end
            S_RTOUCH:
            begin
                op         = pce_pkg::OP_TOUCH;
                state_next = S_SWR;
            end
            S_SWR:
            begin
                op         = pce_pkg::OP_WRITE;
                state_next = S_ENF;
            end
            S_VSCAN:
            begin
                op       = pce_pkg::OP_VIC_SCAN;
                cnt_next = cnt_reg + CNT_W'(1);
                if (scan_done)
                begin
                    if (stat.vic_found)
                    begin
                        state_next = S_EVICT;
                    end
                    else
                    begin
                        state_next = full_reg ? S_NEW : S_OUT;
                    end
                end
            end
            S_EVICT:
            begin
                op         = pce_pkg::OP_EVICT;
                state_next = full_reg ? S_NEW : S_ENF;
                full_next  = 1'b0;
            end
            S_ENF:
            begin
                if (stat.over_cap)
                begin
                    cnt_next   = '0;
                    full_next  = 1'b0;
                    state_next = S_VSCAN;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!stat.out_busy)
                begin
                    op         = pce_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            full_reg  <= full_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign cnt      = cnt_reg;

endmodule

// ===== src/prefix_cache_with_eviction.sv =====
// Prefix cache with eviction: at most one lookup and one insert per request.
// Requests enter on in_valid/in_ready and each gives exactly one result on
// out_valid/out_ready; the next request is taken while a result still waits.
// Configuration is written through the APB port (capacity_limit at 0x0,
// block_size at 0x4, evict_policy at 0x8, decay_factor at 0xC); pready is
// always high, and registers are to be written only while no request is in
// flight; the block itself does not enforce this. A request with a prefix
// runs a key scan over the entry memory (one entry a cycle), the 21-step
// remainder unit that rounds to whole blocks, and the frequency multiply
// and write-back. Each eviction, whether every slot is taken or capacity
// forces it, adds a victim scan over the same port. A request without a
// prefix goes from the branch state straight to the output state.
// One request is handled at a time; the next is accepted at the earliest in
// the cycle in which the result appears.
// Reset empties the cache (valid bits cleared at once, no clearing pass),
// zeroes the touch clock and the token total, and loads the register reset
// values. When the receiver stalls, the result holds in the output register
// and a following request waits at its end stage until the result is taken.
module prefix_cache_with_eviction #(
    parameter int ENTRIES = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pce_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            has_prefix,
    input  logic [pce_pkg::KEY_W-1:0]       prefix_key,
    input  logic [pce_pkg::LEN_W-1:0]       prompt_len,
    input  logic                            has_prefix_len,
    input  logic [pce_pkg::LEN_W-1:0]       prefix_len,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pce_pkg::LEN_W-1:0]       hit_len,
    output logic                            stored,
    output logic [pce_pkg::EVC_W-1:0]       evicted_count,
    output logic [pce_pkg::TOK_W-1:0]       occupied_tokens
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_WS = $clog2(ENTRIES + 1);
    localparam int CNT_W  = (CNT_WS > 5) ? CNT_WS : 5;

    logic [pce_pkg::TOK_W-1:0]      capacity_reg;
    logic [pce_pkg::BS_W-1:0]       block_reg;
    logic [pce_pkg::POL_W-1:0]      policy_reg;
    logic [pce_pkg::DECAY_W-1:0]    decay_reg;
    logic                           cfg_wr;
    pce_pkg::op_t                   op;
    logic [CNT_W-1:0]               cnt;
    pce_pkg::status_t               stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= '0;
            block_reg    <= pce_pkg::BS_W'(16);
            policy_reg   <= '0;
            decay_reg    <= pce_pkg::DECAY_W'(65536);
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                pce_pkg::REG_CAPACITY: capacity_reg <= pwdata;
                pce_pkg::REG_BLOCK:    block_reg    <= pwdata[pce_pkg::BS_W-1:0];
                pce_pkg::REG_POLICY:   policy_reg   <= pwdata[pce_pkg::POL_W-1:0];
                pce_pkg::REG_DECAY:    decay_reg    <= pwdata[pce_pkg::DECAY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            pce_pkg::REG_CAPACITY: prdata = capacity_reg;
            pce_pkg::REG_BLOCK:    prdata = 32'(block_reg);
            pce_pkg::REG_POLICY:   prdata = 32'(policy_reg);
            pce_pkg::REG_DECAY:    prdata = 32'(decay_reg);
            default:               prdata = '0;
        endcase
    end

    pce_ctrl #(
        .ENTRIES (ENTRIES),
        .CNT_W   (CNT_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .op       (op),
        .cnt      (cnt)
    );

    pce_dp #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .op              (op),
        .cnt             (cnt),
        .stat            (stat),
        .capacity_limit  (capacity_reg),
        .block_size      (block_reg),
        .evict_policy    (policy_reg),
        .decay_factor    (decay_reg),
        .has_prefix      (has_prefix),
        .prefix_key      (prefix_key),
        .prompt_len      (prompt_len),
        .has_prefix_len  (has_prefix_len),
        .prefix_len      (prefix_len),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .hit_len         (hit_len),
        .stored          (stored),
        .evicted_count   (evicted_count),
        .occupied_tokens (occupied_tokens)
    );

endmodule
